### rtl/biquad_cascade_df1_q15_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the biquad cascade
// Both macros expect signals named clk and rst in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_DF1_Q15_ASSERT_SVH
`define BIQUAD_CASCADE_DF1_Q15_ASSERT_SVH

// Same-cycle implication.
`define BQC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("biquad cascade: same-cycle check failed");

// Next-cycle implication.
`define BQC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("biquad cascade: next-cycle check failed");

`endif

### rtl/bqc_pkg.sv
// ---------------------------------------------------------------------------
// bqc_pkg
// Shared types, codes and helpers of the Q15 biquad cascade.
// ---------------------------------------------------------------------------
package bqc_pkg;

  localparam int MAX_STAGES_DEF  = 8;
  localparam int COEFS_PER_STAGE = 5;
  localparam int SAMPLE_W        = 16;
  localparam int ACC_W           = 32;
  localparam int FRAC_BITS       = 15;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 4;
  localparam int COEF_IDX_W      = 6;
  localparam int HIST_W          = 4 * SAMPLE_W;

  localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_STAGES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POST_SHIFT = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch the incoming sample
    logic coef_we;   // store the incoming coefficient
    logic mul;       // form the five products
    logic acc;       // sum the products
    logic sat;       // shift, saturate, update history
    logic load_out;  // move the result into the output register
  } bqc_cmd_t;

  typedef struct packed {
    logic out_full;
  } bqc_stat_t;

  // Stage number of a coefficient index: idx / 5 as (idx * 13) >> 6,
  // exact for every 6-bit index.
  function automatic logic [3:0] coef_stage(input logic [COEF_IDX_W-1:0] idx);
    logic [9:0] prod;
    prod = 10'(idx) * 10'd13;
    return prod[9:6];
  endfunction

endpackage

### rtl/bqc_ram.sv
// ---------------------------------------------------------------------------
// bqc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bqc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bqc_ctrl.sv
// ---------------------------------------------------------------------------
// bqc_ctrl
// Sequencer: walks one sample through the active stages, four steps each.
// ---------------------------------------------------------------------------
module bqc_ctrl #(
  parameter int MAX_STAGES = bqc_pkg::MAX_STAGES_DEF,
  localparam int STAGE_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [3:0]          num_stages,
  input  logic                out_ready,
  input  bqc_pkg::bqc_stat_t  stat,
  output bqc_pkg::bqc_cmd_t   ctl,
  output logic [STAGE_W-1:0]  stage,
  output logic [STAGE_W-1:0]  last_stage
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_SAT   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int CNT_W = $clog2(MAX_STAGES + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  logic [2:0]       state, state_next;
  logic [CMP_W-1:0] ns_x, n_lim;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Clamp the stage count to 1 .. MAX_STAGES.
  always_comb begin
    ns_x = CMP_W'(num_stages);
    if (ns_x == '0) begin
      n_lim = CMP_W'(1);
    end else if (ns_x > CMP_W'(MAX_STAGES)) begin
      n_lim = CMP_W'(MAX_STAGES);
    end else begin
      n_lim = ns_x;
    end
  end

  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.coef_we  = accept && (cmd == bqc_pkg::CMD_COEF);
    ctl.start    = accept && (cmd == bqc_pkg::CMD_SAMPLE);
    unique case (state)
      S_IDLE: begin
        if (ctl.start) state_next = S_FETCH;
      end
      S_FETCH: state_next = S_MUL;
      S_MUL: begin
        ctl.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        ctl.acc    = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        ctl.sat    = 1'b1;
        state_next = (stage == last_stage) ? S_OUT : S_FETCH;
      end
      S_OUT: begin
        if (!stat.out_full || out_ready) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stage      <= '0;
      last_stage <= '0;
    end else begin
      state <= state_next;
      if (ctl.start) begin
        stage      <= '0;
        last_stage <= STAGE_W'(n_lim - CMP_W'(1));
      end else if (ctl.sat && (stage != last_stage)) begin
        stage <= stage + STAGE_W'(1);
      end
    end
  end

endmodule

### rtl/bqc_datapath.sv
// ---------------------------------------------------------------------------
// bqc_datapath
// Coefficient and history stores, five-product MAC, shift and saturation.
// ---------------------------------------------------------------------------
module bqc_datapath #(
  parameter int MAX_STAGES = bqc_pkg::MAX_STAGES_DEF,
  localparam int STAGE_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bqc_pkg::bqc_cmd_t                     ctl,
  output bqc_pkg::bqc_stat_t                    stat,
  input  logic [STAGE_W-1:0]                    stage,
  input  logic [3:0]                            post_shift,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic [bqc_pkg::COEF_IDX_W-1:0]        coef_index,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0]   coef_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bqc_pkg::SAMPLE_W-1:0]   sample_out
);

  localparam int SW     = bqc_pkg::SAMPLE_W;
  localparam int AW     = bqc_pkg::ACC_W;
  localparam int NK     = bqc_pkg::COEFS_PER_STAGE;
  localparam int DEPTH  = NK * MAX_STAGES;
  localparam int DEPTHW = $clog2(DEPTH + 1);
  localparam int IXW    = (DEPTHW > bqc_pkg::COEF_IDX_W) ? DEPTHW : bqc_pkg::COEF_IDX_W;
  localparam int QW     = (STAGE_W > 4) ? STAGE_W : 4;

  // Coefficient write decode: stage and tap of the index.
  logic [3:0]         wq;
  logic [QW-1:0]      wq_x;
  logic [2:0]         wk;
  logic               idx_ok;
  logic [STAGE_W-1:0] wstage;

  always_comb begin
    wq     = bqc_pkg::coef_stage(coef_index);
    wq_x   = QW'(wq);
    wstage = wq_x[STAGE_W-1:0];
    wk     = 3'(coef_index - 6'(wq) * 6'd5);
    idx_ok = IXW'(coef_index) < IXW'(DEPTH);
  end

  logic signed [SW-1:0] coef_q [NK];

  for (genvar k = 0; k < NK; k++) begin : g_coef
    bqc_ram #(.WIDTH(SW), .DEPTH(MAX_STAGES)) u_coef (
      .clk   (clk),
      .we    (ctl.coef_we && idx_ok && (wk == 3'(k))),
      .waddr (wstage),
      .wdata (coef_value),
      .raddr (stage),
      .rdata (coef_q[k])
    );
  end

  // History per stage: {x1, x2, y1, y2}; a stage never run reads as zero.
  logic [bqc_pkg::HIST_W-1:0] hist_q, hist_wdata;
  logic [MAX_STAGES-1:0]      hist_valid;
  logic                       hv_q;

  bqc_ram #(.WIDTH(bqc_pkg::HIST_W), .DEPTH(MAX_STAGES)) u_hist (
    .clk   (clk),
    .we    (ctl.sat),
    .waddr (stage),
    .wdata (hist_wdata),
    .raddr (stage),
    .rdata (hist_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (ctl.sat) begin
      hist_valid[stage] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    hv_q <= hist_valid[stage];
  end

  logic signed [SW-1:0] h_x1, h_x2, h_y1, h_y2;

  always_comb begin
    if (hv_q) begin
      {h_x1, h_x2, h_y1, h_y2} = hist_q;
    end else begin
      {h_x1, h_x2, h_y1, h_y2} = '0;
    end
  end

  // Arithmetic pipeline registers.
  logic signed [SW-1:0] x, x1_keep, y1_keep, y;
  logic signed [AW-1:0] p0, p1, p2, p3, p4, acc, shifted;
  logic [3:0]           sh;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x <= sample_in;
    end else if (ctl.sat) begin
      x <= y;
    end
    if (ctl.mul) begin
      p0      <= coef_q[0] * x;
      p1      <= coef_q[1] * h_x1;
      p2      <= coef_q[2] * h_x2;
      p3      <= coef_q[3] * h_y1;
      p4      <= coef_q[4] * h_y2;
      x1_keep <= h_x1;
      y1_keep <= h_y1;
    end
    if (ctl.acc) begin
      acc <= p0 + p1 + p2 - p3 - p4;
    end
  end

  // Scale and saturate to Q15.
  always_comb begin
    sh      = 4'(bqc_pkg::FRAC_BITS) - post_shift;
    shifted = acc >>> sh;
    if (shifted > AW'(bqc_pkg::Q15_MAX)) begin
      y = bqc_pkg::Q15_MAX;
    end else if (shifted < AW'(bqc_pkg::Q15_MIN)) begin
      y = bqc_pkg::Q15_MIN;
    end else begin
      y = shifted[SW-1:0];
    end
    hist_wdata = {x, x1_keep, y, y1_keep};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      sample_out <= x;
    end
  end

  assign stat.out_full = out_valid;

endmodule

### rtl/biquad_cascade_df1_q15.sv
// A sample word runs fetch, multiply, sum and saturate in each of the N active stages, then waits
// for room in the output register; no new word is taken until it is handed off to sample_out.
// Coefficient words are taken one per cycle while the block is idle and give no result.
// Reset: history reads as zero at once through per-stage valid flags; coefficients stay undefined.
// Reset sets num_stages to 1 and post_shift to 0; there is no clearing pass.
// ---------------------------------------------------------------------------
// biquad_cascade_df1_q15
// Cascade of Q15 direct-form-I biquad sections with a sequenced shared MAC.
// ---------------------------------------------------------------------------
`include "biquad_cascade_df1_q15_assert.svh"

module biquad_cascade_df1_q15 #(
  parameter int MAX_STAGES = bqc_pkg::MAX_STAGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic [bqc_pkg::COEF_IDX_W-1:0]        coef_index,
  input  logic signed [bqc_pkg::SAMPLE_W-1:0]   coef_value,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bqc_pkg::SAMPLE_W-1:0]   sample_out,
  // configuration write port
  input  logic                                  cfg_wen,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bqc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int STAGE_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  // Configuration registers; writes to unused indexes drop.
  logic [3:0] num_stages;
  logic [3:0] post_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_stages <= 4'd1;
      post_shift <= 4'd0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        bqc_pkg::REG_NUM_STAGES: num_stages <= cfg_data;
        bqc_pkg::REG_POST_SHIFT: post_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  bqc_pkg::bqc_cmd_t  ctl;
  bqc_pkg::bqc_stat_t stat;
  logic [STAGE_W-1:0] stage;
  logic [STAGE_W-1:0] last_stage;

  // Sequencer: accepts words in idle, then steps each stage through
  // fetch, multiply, sum and saturate, and finally hands off the result.
  bqc_ctrl #(.MAX_STAGES(MAX_STAGES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .num_stages (num_stages),
    .out_ready  (out_ready),
    .stat       (stat),
    .ctl        (ctl),
    .stage      (stage),
    .last_stage (last_stage)
  );

  // Datapath: coefficient RAMs, history RAM, MAC and the output register,
  // which holds a finished word while the next one is taken in.
  bqc_datapath #(.MAX_STAGES(MAX_STAGES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .stage      (stage),
    .post_shift (post_shift),
    .sample_in  (sample_in),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

  // A taken sample word puts the block to work at the next edge.
  `BQC_ASSERT_NEXT(a_busy_after_sample, ctl.start, !in_ready)
  // The stage counter never passes the last active stage.
  `BQC_ASSERT_IMPL(a_stage_bound, !in_ready, stage <= last_stage)
  // A new result never overwrites one that is still waiting.
  `BQC_ASSERT_IMPL(a_no_overwrite, ctl.load_out, !out_valid || out_ready)

endmodule
